// ===== rtl/pom_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Path ORAM controller package
// Shared sizes, request and result types, and tree addressing helpers.
// ----------------------------------------------------------------------------
package pom_pkg;

    localparam int LEVELS           = 4;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int BLOCK_COUNT      = 16;
    localparam int STASH_DEPTH      = 32;
    localparam int PAYLOAD_BITS     = 32;

    localparam int LEAF_W      = LEVELS - 1;
    localparam int LEAF_COUNT  = 1 << LEAF_W;
    localparam int BKT_COUNT   = (1 << LEVELS) - 1;
    localparam int SLOT_COUNT  = BKT_COUNT * SLOTS_PER_BUCKET;
    localparam int BKT_W       = LEVELS;
    localparam int LVL_W       = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int SLOT_W      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int USED_W      = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int TADDR_W     = $clog2(SLOT_COUNT);
    localparam int IDX_W       = $clog2(BLOCK_COUNT);
    localparam int STASH_AW    = $clog2(STASH_DEPTH);
    localparam int FILL_W      = STASH_AW + 1;

    typedef struct packed {
        logic        kind;
        logic [3:0]  block_index;
        logic [31:0] write_data;
        logic [2:0]  fresh_leaf;
    } t_request;

    typedef struct packed {
        logic [31:0] read_data;
        logic        found;
        logic        overflow;
    } t_result;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic [PAYLOAD_BITS-1:0] data;
    } t_entry;

    // Bucket on the path to a leaf at a given level; the root is bucket 0.
    function automatic logic [BKT_W-1:0] bucket_of(input logic [LEAF_W-1:0] leaf,
                                                    input logic [LVL_W-1:0] lvl);
        logic [BKT_W-1:0] base;
        logic [BKT_W-1:0] off;
        base = BKT_W'((BKT_W'(1) << lvl) - BKT_W'(1));
        off  = BKT_W'(leaf >> (LEAF_W - int'(lvl)));
        return base + off;
    endfunction

    function automatic logic [TADDR_W-1:0] slot_addr(input logic [BKT_W-1:0] bkt,
                                                      input logic [USED_W-1:0] slot);
        return TADDR_W'(int'(bkt) * SLOTS_PER_BUCKET + int'(slot));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pom_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/pom_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Path match unit
// Tells whether a leaf's path passes through the old path's bucket at a level.
// ----------------------------------------------------------------------------
module pom_match (
    input  wire logic [pom_pkg::LEAF_W-1:0] i_leaf,
    input  wire logic [pom_pkg::LEAF_W-1:0] i_old_leaf,
    input  wire logic [pom_pkg::LVL_W-1:0]  i_lvl,
    output logic                            o_match
);
    // Two leaves share a bucket at a level when their top bits agree.
    always_comb begin
        o_match = ((i_leaf >> (pom_pkg::LEAF_W - int'(i_lvl))) ==
                   (i_old_leaf >> (pom_pkg::LEAF_W - int'(i_lvl))));
    end
endmodule
`default_nettype wire

// ===== rtl/path_oram_controller_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Path ORAM controller core
// Sequenced tree, stash and position map with one access in flight.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where i_start is high and o_busy is low.
// It carries the access kind, the block index, write data and a fresh leaf.
// The block first remaps the index, then reads every valid slot on the old
// path (root to leaf) into the stash, serves the access by scanning the stash
// and finally evicts greedily from the leaf level to the root, scanning every
// stash entry at each level. o_busy stays high throughout the access.
// The result is shown on o_result with o_done high for exactly one cycle;
// the receiver cannot stall it. A new request may be taken in that same
// cycle. A full stash drops the block and raises the overflow flag. Reset
// clears the slot valid bits, the stash fill count and the position map
// valid bits, so the map reads as index modulo leaf count.
// ----------------------------------------------------------------------------
module path_oram_controller_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire pom_pkg::t_request i_req,
    output logic                   o_busy,
    output logic                   o_done,
    output pom_pkg::t_result       o_result
);
    typedef enum logic [2:0] {
        S_IDLE, S_LMAP, S_PREAD, S_SERVE, S_EVICT
    } t_state;

    t_state                              r_state;
    logic [1:0]                          r_ph;
    logic                                r_kind;
    logic [pom_pkg::IDX_W-1:0]           r_idx;
    logic [pom_pkg::PAYLOAD_BITS-1:0]    r_wdata;
    logic [pom_pkg::LEAF_W-1:0]          r_new_leaf;
    logic [pom_pkg::LEAF_W-1:0]          r_old_leaf;
    logic [pom_pkg::LVL_W-1:0]           r_lvl;
    logic [pom_pkg::USED_W-1:0]          r_slot;
    logic [pom_pkg::FILL_W-1:0]          r_i;
    logic [pom_pkg::FILL_W-1:0]          r_fill;
    logic [pom_pkg::FILL_W-1:0]          r_keep;
    logic [pom_pkg::USED_W-1:0]          r_used;
    logic                                r_found;
    logic                                r_ovf;
    logic [pom_pkg::PAYLOAD_BITS-1:0]    r_rdata;
    pom_pkg::t_entry                     r_ent;
    logic [pom_pkg::SLOT_COUNT-1:0]      r_tvalid;
    logic [pom_pkg::BLOCK_COUNT-1:0]     r_lmv;
    logic [pom_pkg::IDX_W-1:0]           r_lm_a;
    logic                                r_done;
    pom_pkg::t_result                    r_result;

    // RAM controls.
    logic                                tr_we, st_we, lm_we;
    logic [pom_pkg::TADDR_W-1:0]         tr_waddr, tr_raddr;
    logic [pom_pkg::STASH_AW-1:0]        st_waddr, st_raddr;
    logic [pom_pkg::IDX_W-1:0]           lm_waddr, lm_raddr;
    pom_pkg::t_entry                     tr_wdata, tr_q, st_wdata, st_q;
    logic [pom_pkg::LEAF_W-1:0]          lm_wdata, lm_q, lm_val;
    logic                                match;
    logic [pom_pkg::BKT_W-1:0]           cur_bkt;
    logic [pom_pkg::TADDR_W-1:0]         pr_addr;
    logic                                stash_room;
    logic                                last_slot, last_lvl;

    pom_ram #(.WIDTH($bits(pom_pkg::t_entry)), .DEPTH(pom_pkg::SLOT_COUNT)) u_tree (
        .i_clk(i_clk), .i_we(tr_we), .i_waddr(tr_waddr), .i_wdata(tr_wdata),
        .i_raddr(tr_raddr), .o_rdata(tr_q)
    );

    pom_ram #(.WIDTH($bits(pom_pkg::t_entry)), .DEPTH(pom_pkg::STASH_DEPTH)) u_stash (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_q)
    );

    pom_ram #(.WIDTH(pom_pkg::LEAF_W), .DEPTH(pom_pkg::BLOCK_COUNT)) u_lmap (
        .i_clk(i_clk), .i_we(lm_we), .i_waddr(lm_waddr), .i_wdata(lm_wdata),
        .i_raddr(lm_raddr), .o_rdata(lm_q)
    );

    pom_match u_match (
        .i_leaf(lm_val), .i_old_leaf(r_old_leaf), .i_lvl(r_lvl), .o_match(match)
    );

    // A position map entry never written still holds its reset leaf.
    assign lm_val     = r_lmv[r_lm_a] ? lm_q : r_lm_a[pom_pkg::LEAF_W-1:0];
    assign cur_bkt    = pom_pkg::bucket_of(r_old_leaf, r_lvl);
    assign pr_addr    = pom_pkg::slot_addr(cur_bkt, r_slot);
    assign stash_room = (r_fill < pom_pkg::FILL_W'(pom_pkg::STASH_DEPTH));
    assign last_slot  = (r_slot == pom_pkg::USED_W'(pom_pkg::SLOTS_PER_BUCKET - 1));
    assign last_lvl   = (r_lvl == pom_pkg::LVL_W'(pom_pkg::LEVELS - 1));

    always_comb begin
        tr_we    = 1'b0;
        tr_waddr = pom_pkg::slot_addr(cur_bkt, r_used);
        tr_wdata = r_ent;
        tr_raddr = pr_addr;
        st_we    = 1'b0;
        st_waddr = r_fill[pom_pkg::STASH_AW-1:0];
        st_wdata = tr_q;
        st_raddr = r_i[pom_pkg::STASH_AW-1:0];
        lm_we    = 1'b0;
        lm_waddr = r_idx;
        lm_wdata = r_new_leaf;
        lm_raddr = r_idx;
        case (r_state)
            S_LMAP: begin
                lm_we = (r_ph == 2'd1);
            end
            S_PREAD: begin
                st_we = (r_ph == 2'd1) && stash_room;
            end
            S_SERVE: begin
                if (r_ph == 2'd0) begin
                    // A write that missed creates the block at the stash tail.
                    st_we    = (r_i == r_fill) && r_kind && stash_room;
                    st_wdata = '{idx: r_idx, data: r_wdata};
                end else begin
                    st_we    = (st_q.idx == r_idx) && r_kind;
                    st_waddr = r_i[pom_pkg::STASH_AW-1:0];
                    st_wdata = '{idx: r_idx, data: r_wdata};
                end
            end
            S_EVICT: begin
                lm_raddr = st_q.idx;
                if (r_ph == 2'd2) begin
                    if (match && (r_used < pom_pkg::USED_W'(pom_pkg::SLOTS_PER_BUCKET))) begin
                        tr_we = 1'b1;
                    end else begin
                        st_we    = 1'b1;
                        st_waddr = r_keep[pom_pkg::STASH_AW-1:0];
                        st_wdata = r_ent;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lm_a <= lm_raddr;
        // The result strobe follows the last eviction step of the root level.
        r_done <= i_rst_n && (r_state == S_EVICT) && (r_ph == 2'd0) &&
                  (r_i == r_fill) && (r_lvl == '0);
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= 2'd0;
            r_fill   <= '0;
            r_used   <= '0;
            r_tvalid <= '0;
            r_lmv    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind     <= i_req.kind;
                        r_idx      <= pom_pkg::IDX_W'(i_req.block_index);
                        r_wdata    <= pom_pkg::PAYLOAD_BITS'(i_req.write_data);
                        r_new_leaf <= pom_pkg::LEAF_W'(i_req.fresh_leaf);
                        r_found    <= 1'b0;
                        r_ovf      <= 1'b0;
                        r_rdata    <= '0;
                        r_ph       <= 2'd0;
                        r_state    <= S_LMAP;
                    end
                end
                S_LMAP: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_old_leaf   <= lm_val;
                        r_lmv[r_idx] <= 1'b1;
                        r_lvl        <= '0;
                        r_slot       <= '0;
                        r_ph         <= 2'd0;
                        r_state      <= S_PREAD;
                    end
                end
                S_PREAD: begin
                    if ((r_ph == 2'd0) && r_tvalid[pr_addr]) begin
                        r_ph <= 2'd1;
                    end else begin
                        if (r_ph == 2'd1) begin
                            r_tvalid[pr_addr] <= 1'b0;
                            if (stash_room) begin
                                r_fill <= r_fill + 1'b1;
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                        r_ph <= 2'd0;
                        if (last_slot) begin
                            r_slot <= '0;
                            if (last_lvl) begin
                                r_i     <= '0;
                                r_state <= S_SERVE;
                            end else begin
                                r_lvl <= r_lvl + 1'b1;
                            end
                        end else begin
                            r_slot <= r_slot + 1'b1;
                        end
                    end
                end
                S_SERVE: begin
                    if (r_ph == 2'd0) begin
                        if (r_i == r_fill) begin
                            if (r_kind) begin
                                if (stash_room) begin
                                    r_fill <= r_fill + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            r_lvl   <= pom_pkg::LVL_W'(pom_pkg::LEVELS - 1);
                            r_i     <= '0;
                            r_keep  <= '0;
                            r_used  <= '0;
                            r_state <= S_EVICT;
                        end else begin
                            r_ph <= 2'd1;
                        end
                    end else begin
                        r_ph <= 2'd0;
                        if (st_q.idx == r_idx) begin
                            r_found <= 1'b1;
                            if (!r_kind) begin
                                r_rdata <= st_q.data;
                            end
                            r_lvl   <= pom_pkg::LVL_W'(pom_pkg::LEVELS - 1);
                            r_i     <= '0;
                            r_keep  <= '0;
                            r_used  <= '0;
                            r_state <= S_EVICT;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_EVICT: begin
                    case (r_ph)
                        2'd0: begin
                            if (r_i == r_fill) begin
                                r_fill <= r_keep;
                                r_i    <= '0;
                                r_keep <= '0;
                                r_used <= '0;
                                if (r_lvl == '0) begin
                                    r_result.read_data <= r_kind ? 32'd0 : r_rdata[31:0];
                                    r_result.found     <= r_found;
                                    r_result.overflow  <= r_ovf;
                                    r_state            <= S_IDLE;
                                end else begin
                                    r_lvl <= r_lvl - 1'b1;
                                end
                            end else begin
                                r_ph <= 2'd1;
                            end
                        end
                        2'd1: begin
                            r_ent <= st_q;
                            r_ph  <= 2'd2;
                        end
                        default: begin
                            if (tr_we) begin
                                r_tvalid[tr_waddr] <= 1'b1;
                                r_used             <= r_used + 1'b1;
                            end else begin
                                r_keep <= r_keep + 1'b1;
                            end
                            r_i  <= r_i + 1'b1;
                            r_ph <= 2'd0;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= pom_pkg::FILL_W'(pom_pkg::STASH_DEPTH))
        else $error("stash fill beyond depth");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= pom_pkg::USED_W'(pom_pkg::SLOTS_PER_BUCKET))
        else $error("bucket over-filled");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_done))
        else $error("request not taken");

endmodule
`default_nettype wire
